// File: src/ifke_pkg.sv
`timescale 1ns / 1ps

package ifke_pkg;

    localparam logic [15:0] ETHERTYPE_VLAN = 16'h8100;
    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;
    localparam logic [5:0]  MIN_HDR_BYTES  = 6'd20;
    localparam logic [5:0]  ETH_TYPE_HI    = 6'd12;
    localparam logic [5:0]  ETH_TYPE_LO    = 6'd13;
    localparam logic [5:0]  VLAN_TYPE_HI   = 6'd2;
    localparam logic [5:0]  VLAN_TYPE_LO   = 6'd3;
    localparam logic [5:0]  IP_VER_IHL     = 6'd0;
    localparam logic [5:0]  IP_PROTO       = 6'd9;
    localparam logic [5:0]  IP_SRC_FIRST   = 6'd12;
    localparam logic [5:0]  IP_DST_FIRST   = 6'd16;
    localparam logic [5:0]  IP_DST_LAST    = 6'd19;
    localparam logic [5:0]  L4_SRC_HI      = 6'd0;
    localparam logic [5:0]  L4_SRC_LO      = 6'd1;
    localparam logic [5:0]  L4_DST_HI      = 6'd2;
    localparam logic [5:0]  L4_DST_LO      = 6'd3;

    localparam int unsigned FMIX_SHIFT = 33;
    localparam logic [63:0] FMIX_C1    = 64'hff51afd7ed558ccd;
    localparam logic [63:0] FMIX_C2    = 64'hc4ceb9fe1a85ec53;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic        flow_found;
        logic [31:0] first_addr;
        logic [31:0] second_addr;
        logic [15:0] first_port;
        logic [15:0] second_port;
        logic [4:0]  protocol;
        logic [63:0] flow_hash;
    } out_item_t;

    typedef struct packed {
        logic        found;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [7:0]  protocol;
    } flow_key_t;

    typedef struct packed {
        logic take;
        logic capture;
        logic init_x;
        logic mul0;
        logic mul1;
        logic mul2;
        logic mix;
        logic const_sel;
        logic fmix_sel;
    } ifke_cmd_t;

endpackage

// File: src/ifke_parser.sv
`timescale 1ns / 1ps

module ifke_parser
    import ifke_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      take,
    input  in_item_t  in_data,
    output flow_key_t key
);

    typedef enum logic [5:0] {
        PH_ETH  = 6'b000001,
        PH_VLAN = 6'b000010,
        PH_IP   = 6'b000100,
        PH_L4   = 6'b001000,
        PH_DONE = 6'b010000,
        PH_SKIP = 6'b100000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [5:0]  count_reg, count_next;
    logic [15:0] ethertype_reg, ethertype_next;
    logic [5:0]  hdr_len_reg, hdr_len_next;
    logic [7:0]  proto_reg, proto_next;
    logic [31:0] src_addr_reg, src_addr_next;
    logic [31:0] dst_addr_reg, dst_addr_next;
    logic [15:0] sport_reg, sport_next;
    logic [15:0] dport_reg, dport_next;
    logic        complete_reg, complete_next;

    logic [7:0]  b;
    logic [5:0]  c;
    logic [6:0]  c_plus;
    logic        inc;
    logic [15:0] et;
    logic [5:0]  hl;
    logic [4:0]  sh;

    function automatic phase_t route(input logic [15:0] t);
        phase_t p;
        if (t == ETHERTYPE_VLAN)
            p = PH_VLAN;
        else if (t == ETHERTYPE_IPV4)
            p = PH_IP;
        else
            p = PH_SKIP;
        return p;
    endfunction

    always_comb
    begin
        b              = in_data.data_byte;
        c              = count_reg;
        c_plus         = {1'b0, count_reg} + 7'd1;
        sh             = {c[1:0], 3'b000};
        et             = '0;
        hl             = '0;
        inc            = 1'b0;
        phase_next     = phase_reg;
        count_next     = count_reg;
        ethertype_next = ethertype_reg;
        hdr_len_next   = hdr_len_reg;
        proto_next     = proto_reg;
        src_addr_next  = src_addr_reg;
        dst_addr_next  = dst_addr_reg;
        sport_next     = sport_reg;
        dport_next     = dport_reg;
        complete_next  = complete_reg;
        unique case (phase_reg)
            PH_ETH:
            begin
                inc = 1'b1;
                if (c == ETH_TYPE_HI)
                    ethertype_next = {b, 8'h00};
                if (c == ETH_TYPE_LO)
                begin
                    et             = {ethertype_reg[15:8], b};
                    ethertype_next = et;
                    count_next     = '0;
                    inc            = 1'b0;
                    phase_next     = route(et);
                end
            end
            PH_VLAN:
            begin
                inc = 1'b1;
                if (c == VLAN_TYPE_HI)
                    ethertype_next = {b, 8'h00};
                if (c == VLAN_TYPE_LO)
                begin
                    et             = {ethertype_reg[15:8], b};
                    ethertype_next = et;
                    count_next     = '0;
                    inc            = 1'b0;
                    phase_next     = route(et);
                end
            end
            PH_IP:
            begin
                inc = 1'b1;
                if (c == IP_VER_IHL)
                begin
                    hl           = {b[3:0], 2'b00};
                    hdr_len_next = hl;
                    if (hl < MIN_HDR_BYTES)
                    begin
                        phase_next = PH_SKIP;
                        inc        = 1'b0;
                    end
                end
                if (c == IP_PROTO)
                begin
                    proto_next = b;
                    if (b != PROTO_TCP && b != PROTO_UDP)
                    begin
                        phase_next = PH_SKIP;
                        inc        = 1'b0;
                    end
                end
                if (c >= IP_SRC_FIRST && c < IP_DST_FIRST)
                    src_addr_next = src_addr_reg | ({24'h0, b} << sh);
                if (c >= IP_DST_FIRST && c <= IP_DST_LAST)
                    dst_addr_next = dst_addr_reg | ({24'h0, b} << sh);
                if (c >= IP_DST_LAST && c_plus >= {1'b0, hdr_len_reg})
                begin
                    phase_next = PH_L4;
                    count_next = '0;
                    inc        = 1'b0;
                end
            end
            PH_L4:
            begin
                inc = 1'b1;
                if (c == L4_SRC_HI)
                    sport_next = {b, 8'h00};
                if (c == L4_SRC_LO)
                    sport_next = {sport_reg[15:8], b};
                if (c == L4_DST_HI)
                    dport_next = {b, 8'h00};
                if (c == L4_DST_LO)
                begin
                    dport_next    = {dport_reg[15:8], b};
                    complete_next = 1'b1;
                    phase_next    = PH_DONE;
                    count_next    = '0;
                    inc           = 1'b0;
                end
            end
            default:
            begin
                inc = 1'b0;
            end
        endcase
        if (inc)
            count_next = c_plus[5:0];
    end

    assign key.found    = complete_next;
    assign key.src_addr = src_addr_next;
    assign key.dst_addr = dst_addr_next;
    assign key.sport    = sport_next;
    assign key.dport    = dport_next;
    assign key.protocol = proto_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_ETH;
            count_reg     <= '0;
            ethertype_reg <= '0;
            hdr_len_reg   <= '0;
            proto_reg     <= '0;
            src_addr_reg  <= '0;
            dst_addr_reg  <= '0;
            sport_reg     <= '0;
            dport_reg     <= '0;
            complete_reg  <= 1'b0;
        end
        else if (take)
        begin
            if (in_data.last_byte)
            begin
                phase_reg     <= PH_ETH;
                count_reg     <= '0;
                ethertype_reg <= '0;
                hdr_len_reg   <= '0;
                proto_reg     <= '0;
                src_addr_reg  <= '0;
                dst_addr_reg  <= '0;
                sport_reg     <= '0;
                dport_reg     <= '0;
                complete_reg  <= 1'b0;
            end
            else
            begin
                phase_reg     <= phase_next;
                count_reg     <= count_next;
                ethertype_reg <= ethertype_next;
                hdr_len_reg   <= hdr_len_next;
                proto_reg     <= proto_next;
                src_addr_reg  <= src_addr_next;
                dst_addr_reg  <= dst_addr_next;
                sport_reg     <= sport_next;
                dport_reg     <= dport_next;
                complete_reg  <= complete_next;
            end
        end
    end

endmodule

// File: src/ifke_ctrl.sv
`timescale 1ns / 1ps

module ifke_ctrl
    import ifke_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      last_byte,
    input  logic      key_found,
    input  logic      out_ready,
    output logic      in_ready,
    output logic      out_valid,
    output ifke_cmd_t cmd
);

    typedef enum logic [6:0] {
        ST_PARSE = 7'b0000001,
        ST_LOAD  = 7'b0000010,
        ST_MUL0  = 7'b0000100,
        ST_MUL1  = 7'b0001000,
        ST_MUL2  = 7'b0010000,
        ST_MIX   = 7'b0100000,
        ST_OUT   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   const_sel_reg, const_sel_next;
    logic   fmix_sel_reg, fmix_sel_next;
    logic   take;

    // while a result waits, non-final bytes of the next frame keep flowing
    assign in_ready  = (state_reg == ST_PARSE) || (state_reg == ST_OUT && !last_byte);
    assign out_valid = (state_reg == ST_OUT);
    assign take      = in_valid && in_ready;

    always_comb
    begin
        state_next     = state_reg;
        const_sel_next = const_sel_reg;
        fmix_sel_next  = fmix_sel_reg;
        cmd            = '0;
        cmd.take       = take;
        cmd.const_sel  = const_sel_reg;
        cmd.fmix_sel   = fmix_sel_reg;
        unique case (state_reg)
            ST_PARSE:
            begin
                if (take && last_byte)
                begin
                    cmd.capture    = 1'b1;
                    const_sel_next = 1'b0;
                    fmix_sel_next  = 1'b0;
                    state_next     = key_found ? ST_LOAD : ST_OUT;
                end
            end
            ST_LOAD:
            begin
                cmd.init_x = 1'b1;
                state_next = ST_MUL0;
            end
            ST_MUL0:
            begin
                cmd.mul0   = 1'b1;
                state_next = ST_MUL1;
            end
            ST_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = ST_MIX;
            end
            ST_MIX:
            begin
                cmd.mix = 1'b1;
                if (!const_sel_reg)
                begin
                    const_sel_next = 1'b1;
                    state_next     = ST_MUL0;
                end
                else if (!fmix_sel_reg)
                begin
                    const_sel_next = 1'b0;
                    fmix_sel_next  = 1'b1;
                    state_next     = ST_LOAD;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_ready)
                    state_next = ST_PARSE;
            end
            default:
            begin
                state_next = ST_PARSE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_PARSE;
            const_sel_reg <= 1'b0;
            fmix_sel_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            const_sel_reg <= const_sel_next;
            fmix_sel_reg  <= fmix_sel_next;
        end
    end

endmodule

// File: src/ifke_datapath.sv
`timescale 1ns / 1ps

module ifke_datapath
    import ifke_pkg::*;
(
    input  logic      clk,
    input  ifke_cmd_t cmd,
    input  flow_key_t key,
    output out_item_t out_data
);

    out_item_t   out_reg;
    logic [63:0] x_reg;
    logic [63:0] acc_reg;

    logic        keep;
    logic [63:0] seed;
    logic [63:0] konst;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] prod;
    logic [63:0] mixed;

    // canonical order: smaller address first, ties by smaller port
    assign keep = (key.src_addr < key.dst_addr) ||
                  (key.src_addr == key.dst_addr && key.sport <= key.dport);

    assign seed = cmd.fmix_sel ?
                  {27'h0, out_reg.protocol, out_reg.second_port, out_reg.first_port} :
                  {out_reg.second_addr, out_reg.first_addr};

    assign konst = cmd.const_sel ? FMIX_C2 : FMIX_C1;

    // 64x64 low product from three 32x32 partial products
    always_comb
    begin
        mul_a = x_reg[31:0];
        mul_b = konst[31:0];
        if (cmd.mul1)
            mul_b = konst[63:32];
        if (cmd.mul2)
            mul_a = x_reg[63:32];
    end

    assign prod  = {32'h0, mul_a} * {32'h0, mul_b};
    assign mixed = acc_reg ^ (acc_reg >> FMIX_SHIFT);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            out_reg.flow_found <= key.found;
            out_reg.flow_hash  <= '0;
            if (!key.found)
            begin
                out_reg.first_addr  <= '0;
                out_reg.second_addr <= '0;
                out_reg.first_port  <= '0;
                out_reg.second_port <= '0;
                out_reg.protocol    <= '0;
            end
            else
            begin
                out_reg.first_addr  <= keep ? key.src_addr : key.dst_addr;
                out_reg.second_addr <= keep ? key.dst_addr : key.src_addr;
                out_reg.first_port  <= keep ? key.sport : key.dport;
                out_reg.second_port <= keep ? key.dport : key.sport;
                out_reg.protocol    <= key.protocol[4:0];
            end
        end
        if (cmd.init_x)
            x_reg <= seed ^ (seed >> FMIX_SHIFT);
        if (cmd.mul0)
            acc_reg <= prod;
        if (cmd.mul1 || cmd.mul2)
            acc_reg[63:32] <= acc_reg[63:32] + prod[31:0];
        if (cmd.mix)
        begin
            x_reg <= mixed;
            if (cmd.const_sel)
                out_reg.flow_hash <= out_reg.flow_hash ^ mixed;
        end
    end

    assign out_data = out_reg;

endmodule

// File: src/ipv4_flow_key_extractor.sv
`timescale 1ns / 1ps

// Takes an Ethernet frame one byte per cycle on the input channel, with the final
// byte marked by last_byte, and returns one result per frame: the found flag, the
// canonical IPv4 TCP/UDP five-tuple and a 64-bit hash (xor of two fmix64 passes).
// Bytes inside a frame are taken every cycle. After the last byte of a frame with a
// flow, the hash runs on a single shared 32x32 multiplier, three partial products
// per 64-bit multiply, and the input is held off while the hash runs. A frame without
// a flow gives its all-zero result on the next cycle. While a result waits to be
// taken, the following frame's bytes keep flowing, except its last byte, which
// waits until the result is taken and the hash unit is free again.
module ipv4_flow_key_extractor
    import ifke_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    ifke_cmd_t cmd;
    flow_key_t key;

    ifke_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (cmd.take),
        .in_data (in_data),
        .key     (key)
    );

    ifke_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .last_byte (in_data.last_byte),
        .key_found (key.found),
        .out_ready (out_ready),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    ifke_datapath u_datapath (
        .clk      (clk),
        .cmd      (cmd),
        .key      (key),
        .out_data (out_data)
    );

    a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.flow_found |->
            out_data.flow_hash == '0 && out_data.first_addr == '0 &&
            out_data.second_addr == '0 && out_data.protocol == '0)
        else $error("not-found result carries nonzero fields");

    a_canonical: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.flow_found |->
            (out_data.first_addr < out_data.second_addr) ||
            (out_data.first_addr == out_data.second_addr &&
             out_data.first_port <= out_data.second_port))
        else $error("five-tuple not in canonical order");

    a_protocol: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.flow_found |->
            out_data.protocol == PROTO_TCP[4:0] || out_data.protocol == PROTO_UDP[4:0])
        else $error("found flow with protocol other than tcp or udp");

    a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready && in_data.last_byte |-> !in_ready)
        else $error("final byte taken while previous result pending");

endmodule

// File: sim/tb_ipv4_flow_key_extractor.sv
`timescale 1ns / 1ps

import ifke_pkg::*;

class flow_scoreboard;

    typedef enum logic [2:0]
    {
        PH_ETH_HDR,
        PH_VLAN_TAG,
        PH_IP_HDR,
        PH_PORTS,
        PH_KEY_DONE,
        PH_IGNORE
    } parse_phase_e;

    parse_phase_e phase;
    logic [5:0]   count;
    logic [15:0]  etype;
    logic [5:0]   hdr_len;
    logic [7:0]   proto;
    logic [31:0]  src_addr;
    logic [31:0]  dst_addr;
    logic [15:0]  sport;
    logic [15:0]  dport;
    bit           key_done;

    out_item_t    flow_q[$];
    int unsigned  errors;

    function new();
        clear_frame();
        errors = 0;
    endfunction

    function void clear_frame();
        phase    = PH_ETH_HDR;
        count    = '0;
        etype    = '0;
        hdr_len  = '0;
        proto    = '0;
        src_addr = '0;
        dst_addr = '0;
        sport    = '0;
        dport    = '0;
        key_done = 1'b0;
    endfunction

    function logic [63:0] mix64(logic [63:0] v);
        logic [63:0] x;
        x = v;
        x = x ^ (x >> FMIX_SHIFT);
        x = x * FMIX_C1;
        x = x ^ (x >> FMIX_SHIFT);
        x = x * FMIX_C2;
        x = x ^ (x >> FMIX_SHIFT);
        return x;
    endfunction

    function void pick_payload_phase();
        count = '0;
        if (etype == ETHERTYPE_VLAN)
            phase = PH_VLAN_TAG;
        else if (etype == ETHERTYPE_IPV4)
            phase = PH_IP_HDR;
        else
            phase = PH_IGNORE;
    endfunction

    function void parse_byte(logic [7:0] b);
        logic [5:0] c;
        int         idx;
        c = count;
        case (phase)
            PH_ETH_HDR:
            begin
                if (c == ETH_TYPE_HI)
                    etype = {b, 8'h00};
                if (c == ETH_TYPE_LO)
                begin
                    etype[7:0] = b;
                    pick_payload_phase();
                    return;
                end
            end
            PH_VLAN_TAG:
            begin
                if (c == VLAN_TYPE_HI)
                    etype = {b, 8'h00};
                if (c == VLAN_TYPE_LO)
                begin
                    etype[7:0] = b;
                    pick_payload_phase();
                    return;
                end
            end
            PH_IP_HDR:
            begin
                if (c == IP_VER_IHL)
                begin
                    hdr_len = {b[3:0], 2'b00};
                    if (hdr_len < MIN_HDR_BYTES)
                    begin
                        phase = PH_IGNORE;
                        return;
                    end
                end
                if (c == IP_PROTO)
                begin
                    proto = b;
                    if (b != PROTO_TCP && b != PROTO_UDP)
                    begin
                        phase = PH_IGNORE;
                        return;
                    end
                end
                if (c >= IP_SRC_FIRST && c < IP_DST_FIRST)
                begin
                    idx = (int'(c) - int'(IP_SRC_FIRST)) * 8;
                    src_addr[idx +: 8] = b;
                end
                if (c >= IP_DST_FIRST && c <= IP_DST_LAST)
                begin
                    idx = (int'(c) - int'(IP_DST_FIRST)) * 8;
                    dst_addr[idx +: 8] = b;
                end
                if (c >= IP_DST_LAST && int'(c) + 1 >= int'(hdr_len))
                begin
                    phase = PH_PORTS;
                    count = '0;
                    return;
                end
            end
            PH_PORTS:
            begin
                if (c == L4_SRC_HI)
                    sport = {b, 8'h00};
                if (c == L4_SRC_LO)
                    sport[7:0] = b;
                if (c == L4_DST_HI)
                    dport = {b, 8'h00};
                if (c == L4_DST_LO)
                begin
                    dport[7:0] = b;
                    key_done = 1'b1;
                    phase = PH_KEY_DONE;
                    count = '0;
                    return;
                end
            end
            default:
                return;
        endcase
        count = c + 6'd1;
    endfunction

    function void note_request(in_item_t req);
        out_item_t r;
        bit        keep;
        parse_byte(req.data_byte);
        if (!req.last_byte)
            return;
        r = '0;
        if (key_done)
        begin
            keep = (src_addr < dst_addr) ||
                   (src_addr == dst_addr && sport <= dport);
            r.flow_found = 1'b1;
            if (keep)
            begin
                r.first_addr  = src_addr;
                r.second_addr = dst_addr;
                r.first_port  = sport;
                r.second_port = dport;
            end
            else
            begin
                r.first_addr  = dst_addr;
                r.second_addr = src_addr;
                r.first_port  = dport;
                r.second_port = sport;
            end
            r.protocol  = proto[4:0];
            r.flow_hash = mix64({r.second_addr, r.first_addr}) ^
                          mix64({24'h0, proto, r.second_port, r.first_port});
        end
        flow_q.push_back(r);
        clear_frame();
    endfunction

    function void check_result(out_item_t got);
        out_item_t want;
        bit        bad;
        if (flow_q.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("%0t: result with no frame pending: found=%0d hash=%h",
                         $realtime, got.flow_found, got.flow_hash);
            return;
        end
        want = flow_q.pop_front();
        bad = (got.flow_found !== want.flow_found) ||
              (got.first_addr !== want.first_addr) ||
              (got.second_addr !== want.second_addr) ||
              (got.first_port !== want.first_port) ||
              (got.second_port !== want.second_port) ||
              (got.protocol !== want.protocol) ||
              (got.flow_hash !== want.flow_hash);
        if (bad)
        begin
            errors++;
            if (errors <= 10)
            begin
                $display("%0t: flow mismatch", $realtime);
                $display("  exp found=%0d addr=%h/%h port=%h/%h proto=%0d hash=%h",
                         want.flow_found, want.first_addr, want.second_addr,
                         want.first_port, want.second_port, want.protocol,
                         want.flow_hash);
                $display("  got found=%0d addr=%h/%h port=%h/%h proto=%0d hash=%h",
                         got.flow_found, got.first_addr, got.second_addr,
                         got.first_port, got.second_port, got.protocol,
                         got.flow_hash);
            end
        end
    endfunction

    function int outstanding();
        return flow_q.size();
    endfunction

endclass

module tb_ipv4_flow_key_extractor;

    localparam int          RANDOM_BYTES   = 800;
    localparam int          STALL_LIMIT    = 4000;
    localparam int          SETTLE_CYCLES  = 40;
    localparam logic [15:0] ETHERTYPE_IPV6 = 16'h86DD;
    localparam logic [7:0]  PROTO_ICMP     = 8'd1;
    localparam logic [7:0]  PROTO_ANY_HI   = 8'hFF;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    in_item_t  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_data;

    logic [7:0]     frame[$];
    bit             steady = 1'b0;
    int             idle_cycles = 0;
    flow_scoreboard sb = new();

    ipv4_flow_key_extractor dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_request(in_data);
            if (out_valid && out_ready)
                sb.check_result(out_data);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        wait (idle_cycles >= STALL_LIMIT);
        $display("%0t: no progress for %0d cycles", $realtime, STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    // result side back-pressure
    initial
    begin : rx_pace
        int r;
        int n;
        forever
        begin
            if (steady)
            begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 55)
                begin
                    out_ready <= 1'b1;
                    n = $urandom_range(1, 8);
                end
                else
                begin
                    out_ready <= 1'b0;
                    if (r < 90)
                        n = $urandom_range(1, 3);
                    else if (r < 98)
                        n = $urandom_range(4, 12);
                    else
                        n = $urandom_range(20, 50);
                end
                repeat (n) @(posedge clk);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_byte(logic [7:0] b, logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{data_byte: b, last_byte: last};
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame.size(); i++)
            send_byte(frame[i], i == frame.size() - 1);
        frame.delete();
    endtask

    function automatic void add_random(int n);
        repeat (n) frame.push_back(8'($urandom_range(0, 255)));
    endfunction

    function automatic void add_word(logic [15:0] w);
        frame.push_back(w[15:8]);
        frame.push_back(w[7:0]);
    endfunction

    function automatic void trim_frame(int n);
        while (frame.size() > n)
            void'(frame.pop_back());
    endfunction

    function automatic void build_flow(int vlans, logic [15:0] etype, logic [7:0] ver_ihl,
                                       logic [7:0] proto, logic [31:0] src,
                                       logic [31:0] dst, logic [15:0] sp,
                                       logic [15:0] dp, int trail);
        int n;
        frame.delete();
        add_random(12);
        repeat (vlans)
        begin
            add_word(ETHERTYPE_VLAN);
            add_random(2);
        end
        add_word(etype);
        n = int'(ver_ihl[3:0]) * 4;
        if (n < 20)
            n = 20;
        for (int i = 0; i < n; i++)
        begin
            if (i == 0)
                frame.push_back(ver_ihl);
            else if (i == 9)
                frame.push_back(proto);
            else if (i >= 12 && i < 16)
                frame.push_back(src[(i - 12) * 8 +: 8]);
            else if (i >= 16 && i < 20)
                frame.push_back(dst[(i - 16) * 8 +: 8]);
            else
                frame.push_back(8'($urandom_range(0, 255)));
        end
        add_word(sp);
        add_word(dp);
        add_random(trail);
    endfunction

    function automatic logic [31:0] pick_addr();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 32'h0000_0000;
        if (r == 1)
            return 32'hFFFF_FFFF;
        if (r < 4)
            return 32'h0100_A8C0 + 32'($urandom_range(0, 3));
        return $urandom;
    endfunction

    function automatic logic [15:0] pick_port();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 16'h0000;
        if (r == 1)
            return 16'hFFFF;
        if (r < 4)
            return 16'(16'd80 + $urandom_range(0, 2));
        return 16'($urandom_range(0, 65535));
    endfunction

    function automatic void random_frame();
        int          r;
        int          vlans;
        logic [3:0]  ihl;
        logic [7:0]  proto;
        logic [15:0] etype;
        logic [31:0] src;
        logic [31:0] dst;
        logic [15:0] sp;
        logic [15:0] dp;
        r = $urandom_range(0, 99);
        vlans = (r < 60) ? 0 : (r < 85) ? 1 : (r < 95) ? 2 : 3;
        ihl = ($urandom_range(0, 99) < 70) ? 4'd5 : 4'($urandom_range(5, 15));
        proto = $urandom_range(0, 1) ? PROTO_TCP : PROTO_UDP;
        etype = ETHERTYPE_IPV4;
        src = pick_addr();
        dst = ($urandom_range(0, 99) < 25) ? src : pick_addr();
        sp = pick_port();
        dp = ($urandom_range(0, 99) < 20) ? sp : pick_port();
        r = $urandom_range(0, 99);
        if (r >= 78 && r < 83)
        begin
            do
                etype = 16'($urandom_range(0, 65535));
            while (etype == ETHERTYPE_VLAN || etype == ETHERTYPE_IPV4);
        end
        if (r >= 83 && r < 88)
            ihl = 4'($urandom_range(0, 4));
        if (r >= 88 && r < 93)
        begin
            do
                proto = 8'($urandom_range(0, 255));
            while (proto == PROTO_TCP || proto == PROTO_UDP);
        end
        build_flow(vlans, etype, {4'($urandom_range(0, 15)), ihl}, proto, src, dst,
                   sp, dp, ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(1, 24));
        // truncated frame
        if (r >= 70 && r < 78)
            trim_frame($urandom_range(1, frame.size() - 1));
        // noise
        if (r >= 93)
        begin
            frame.delete();
            add_random($urandom_range(1, 80));
        end
    endfunction

    initial
    begin : stimulus
        int bytes_sent;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // basic tcp, udp with swapped order, equal addresses
        build_flow(0, ETHERTYPE_IPV4, 8'h45, PROTO_TCP, 32'h0100_000A, 32'h0200_000A,
                   16'd1234, 16'd80, 0);
        send_frame();
        build_flow(0, ETHERTYPE_IPV4, 8'h45, PROTO_UDP, 32'h0900_000A, 32'h0200_000A,
                   16'd53, 16'd5353, 0);
        send_frame();
        build_flow(0, ETHERTYPE_IPV4, 8'h45, PROTO_TCP, 32'h0101_A8C0, 32'h0101_A8C0,
                   16'd100, 16'd200, 0);
        send_frame();
        build_flow(0, ETHERTYPE_IPV4, 8'h45, PROTO_TCP, 32'h0101_A8C0, 32'h0101_A8C0,
                   16'd200, 16'd100, 0);
        send_frame();
        build_flow(0, ETHERTYPE_IPV4, 8'h45, PROTO_UDP, 32'h0101_A8C0, 32'h0101_A8C0,
                   16'd777, 16'd777, 0);
        send_frame();
        // extremes
        build_flow(0, ETHERTYPE_IPV4, 8'h45, PROTO_UDP, 32'hFFFF_FFFF, 32'h0000_0000,
                   16'hFFFF, 16'h0000, 0);
        send_frame();
        build_flow(0, ETHERTYPE_IPV4, 8'hFF, PROTO_TCP, 32'h0000_0000, 32'hFFFF_FFFF,
                   16'h0000, 16'hFFFF, 0);
        send_frame();
        // header length below minimum
        build_flow(0, ETHERTYPE_IPV4, 8'h44, PROTO_TCP, pick_addr(), pick_addr(),
                   pick_port(), pick_port(), 0);
        send_frame();
        build_flow(0, ETHERTYPE_IPV4, 8'h40, PROTO_UDP, pick_addr(), pick_addr(),
                   pick_port(), pick_port(), 4);
        send_frame();
        // other protocols and ethertypes
        build_flow(0, ETHERTYPE_IPV4, 8'h45, PROTO_ICMP, pick_addr(), pick_addr(),
                   pick_port(), pick_port(), 0);
        send_frame();
        build_flow(0, ETHERTYPE_IPV4, 8'h45, PROTO_ANY_HI, pick_addr(), pick_addr(),
                   pick_port(), pick_port(), 0);
        send_frame();
        build_flow(0, ETHERTYPE_IPV6, 8'h45, PROTO_TCP, pick_addr(), pick_addr(),
                   pick_port(), pick_port(), 0);
        send_frame();
        // vlan tags
        build_flow(1, ETHERTYPE_IPV4, 8'h45, PROTO_TCP, pick_addr(), pick_addr(),
                   pick_port(), pick_port(), 0);
        send_frame();
        build_flow(2, ETHERTYPE_IPV4, 8'h46, PROTO_UDP, pick_addr(), pick_addr(),
                   pick_port(), pick_port(), 10);
        send_frame();
        // truncated vlan tag
        build_flow(1, ETHERTYPE_IPV4, 8'h45, PROTO_TCP, pick_addr(), pick_addr(),
                   pick_port(), pick_port(), 0);
        trim_frame(15);
        send_frame();
        // short frames
        add_random(1);
        send_frame();
        build_flow(0, ETHERTYPE_IPV4, 8'h45, PROTO_TCP, pick_addr(), pick_addr(),
                   pick_port(), pick_port(), 0);
        trim_frame(30);
        send_frame();
        build_flow(0, ETHERTYPE_IPV4, 8'h45, PROTO_UDP, pick_addr(), pick_addr(),
                   pick_port(), pick_port(), 0);
        trim_frame(frame.size() - 1);
        send_frame();
        // trailing payload
        build_flow(0, ETHERTYPE_IPV4, 8'h46, PROTO_TCP, pick_addr(), pick_addr(),
                   pick_port(), pick_port(), 20);
        send_frame();

        bytes_sent = 0;
        while (bytes_sent < RANDOM_BYTES)
        begin
            steady = ($urandom_range(0, 99) < 15);
            random_frame();
            bytes_sent += frame.size();
            send_frame();
        end
        in_valid <= 1'b0;
        steady = 1'b0;

        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
